// ----- sv/b2b_pkg.sv -----
// Shared types, constants and helper functions for the BLAKE2b hash engine.
// Used by the top level; the buffer RAM is generic and takes no package.
package b2b_pkg;

    localparam int WORD_W      = 64;
    localparam int BUF_DEPTH   = 16;
    localparam int BUF_AW      = $clog2(BUF_DEPTH);
    localparam int BLOCK_BYTES = 128;
    localparam int ROUNDS      = 12;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH    = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] DIGEST_LEN_RESET = 7'd64;
    localparam logic [CFG_DATA_W-1:0] KEY_LEN_RESET    = 7'd0;

    localparam logic [WORD_W-1:0] PARAM_BASE = 64'h0000_0000_0101_0000;
    localparam logic [WORD_W-1:0] LAST_FLAG  = 64'hffff_ffff_ffff_ffff;

    localparam logic [WORD_W-1:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // message schedule, one row per round
    localparam logic [3:0] SIGMA [ROUNDS][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POST,
        ST_INIT,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } t_state;

    // keep the low n bytes of a word, n clipped to eight
    function automatic logic [WORD_W-1:0] byte_mask(input logic [3:0] n);
        logic [WORD_W-1:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] eff_digest_len(input logic [CFG_DATA_W-1:0] d);
        logic [CFG_DATA_W-1:0] r;
        if (d == '0) begin
            r = 7'd1;
        end else if (d > 7'd64) begin
            r = 7'd64;
        end else begin
            r = d;
        end
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] eff_key_len(input logic [CFG_DATA_W-1:0] k);
        return (k > 7'd64) ? 7'd64 : k;
    endfunction

endpackage

// ----- sv/b2b_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependencies.
module b2b_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/blake2b_hash_engine.sv -----
// BLAKE2b streaming hash engine (digest length 1..64 bytes, 64 by default): top level with sequencer and shared G unit.
// Depends on b2b_pkg and on b2b_ram for the 16-word message block buffer.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one beat per message word:
//   eight little-endian bytes, byte count and a final mark. Every beat but the
//   last carries eight bytes; the last carries 0..8 (0 for an empty message).
//   For keyed hashing, feed the key zero-padded to 128 bytes as 16 words first.
//   Output channel (o_out_valid / i_out_ready) returns one beat per 8 digest
//   bytes after the final beat; digest_last marks the closing beat.
//   Configuration writes (digest length, key length) restart the engine.
// Sequence:
//   An ordinary word is stored in the cycle it is accepted. The 17th word of a
//   block first triggers a compression (a load in INIT, 192 half-G steps in
//   ROUND, a fold in FINISH), then is stored in POST. One shared half-G unit
//   runs every step: 12 rounds x 8 G functions x 2 half-G steps. No input is
//   taken while a compression runs. The first digest beat shows once the final
//   block is compressed (after a second compression if the final beat follows a full block).
// Reset and stall:
//   Reset loads the default registers and the initial chain; no clearing pass.
//   While digest beats wait on i_out_ready the engine holds them and takes no
//   input; the next message starts after the last digest beat is taken.
module blake2b_hash_engine import b2b_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // message words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [WORD_W-1:0]     i_data_word,
    input  logic [3:0]            i_byte_count,
    input  logic                  i_final_word,
    // digest words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [WORD_W-1:0]     o_digest_word,
    output logic [3:0]            o_digest_bytes,
    output logic                  o_digest_last
);

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_dig, n_dig;
    logic [CFG_DATA_W-1:0] r_key, n_key;
    logic [WORD_W-1:0]     r_chain [8];
    logic [WORD_W-1:0]     n_chain [8];
    logic [127:0]          r_cnt, n_cnt;
    logic [7:0]            r_fill, n_fill;
    logic [WORD_W-1:0]     r_v [16];
    logic [WORD_W-1:0]     n_v [16];
    logic [3:0]            r_round, n_round;
    logic [2:0]            r_g, n_g;
    logic                  r_h, n_h;
    logic [4:0]            r_nwords, n_nwords;
    logic                  r_last, n_last;
    logic                  r_mvalid, n_mvalid;
    logic [WORD_W-1:0]     r_pend_word, n_pend_word;
    logic [3:0]            r_pend_cnt, n_pend_cnt;
    logic                  r_pend_fin, n_pend_fin;
    logic [2:0]            r_k, n_k;

    // handshakes and write source
    logic              w_acc_in, w_acc_out, w_cfg_hit, w_restart;
    logic [3:0]        w_in_cnt, w_cnt;
    logic [WORD_W-1:0] w_word;
    logic              w_fin, w_need_comp, w_absorb;
    logic [7:0]        w_fill_new;

    // round stepping
    logic       w_last_step;
    logic [3:0] w_nx_round;
    logic [2:0] w_nx_g;
    logic       w_nx_h;
    logic [3:0] w_f_round;
    logic [3:0] w_f_idx;

    // shared half-G unit
    logic [WORD_W-1:0] w_x, w_a1, w_b1, w_c1, w_d1, w_dx, w_bx;
    logic [WORD_W-1:0] w_t [16];
    logic [1:0]        w_sh [4];

    // digest word selection
    logic [CFG_DATA_W-1:0] w_dlen, w_rem;
    logic [3:0]            w_nres, w_nb;

    // configuration next values and restart chain word
    logic [CFG_DATA_W-1:0] w_new_dig, w_new_key;
    logic [WORD_W-1:0]     w_param;

    // buffer RAM ports
    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    b2b_ram #(
        .WIDTH(WORD_W),
        .DEPTH(BUF_DEPTH)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // ---------------------------------------------------------------
    // Handshakes, input word shaping
    // ---------------------------------------------------------------
    assign w_acc_in  = i_in_valid && o_in_ready;
    assign w_acc_out = o_out_valid && i_out_ready;
    assign w_cfg_hit = i_cfg_we &&
                       ((i_cfg_idx == CFG_DIGEST_LENGTH) || (i_cfg_idx == CFG_KEY_LENGTH));
    assign w_restart = w_cfg_hit || (w_acc_out && o_digest_last);

    // short counts only count on the final beat; anything above eight is eight
    assign w_in_cnt = (!i_final_word || (i_byte_count > 4'd8)) ? 4'd8 : i_byte_count;

    // in POST the held beat is stored after the full block went out
    always_comb begin
        if (r_state == ST_POST) begin
            w_word = r_pend_word;
            w_cnt  = r_pend_cnt;
            w_fin  = r_pend_fin;
        end else begin
            w_word = i_data_word & byte_mask(w_in_cnt);
            w_cnt  = w_in_cnt;
            w_fin  = i_final_word;
        end
    end

    assign w_need_comp = (w_cnt != 4'd0) && (r_fill == 8'(BLOCK_BYTES));
    assign w_absorb    = (r_state == ST_POST) ||
                         ((r_state == ST_IDLE) && w_acc_in && !w_need_comp);
    assign w_fill_new  = r_fill + 8'(w_cnt);

    // ---------------------------------------------------------------
    // Round stepper: half-G index within G, G index within round
    // ---------------------------------------------------------------
    assign w_last_step = (r_round == 4'(ROUNDS - 1)) && (r_g == 3'd7) && r_h;

    always_comb begin
        w_nx_h     = ~r_h;
        w_nx_g     = r_h ? r_g + 3'd1 : r_g;
        w_nx_round = r_round;
        if (r_h && (r_g == 3'd7)) begin
            w_nx_round = w_last_step ? 4'd0 : r_round + 4'd1;
        end
        // prefetch the message word of the step that runs next cycle
        if (r_state == ST_INIT) begin
            w_f_round = 4'd0;
            w_f_idx   = 4'd0;
        end else begin
            w_f_round = w_nx_round;
            w_f_idx   = {w_nx_g, w_nx_h};
        end
    end

    assign ram_raddr = SIGMA[w_f_round][w_f_idx];

    // ---------------------------------------------------------------
    // Shared half-G unit on the fixed lanes 0, 4, 8, 12
    // ---------------------------------------------------------------
    assign w_x  = r_mvalid ? ram_rdata : '0;
    assign w_a1 = r_v[0] + r_v[4] + w_x;
    assign w_dx = r_v[12] ^ w_a1;
    assign w_d1 = r_h ? {w_dx[15:0], w_dx[63:16]} : {w_dx[31:0], w_dx[63:32]};
    assign w_c1 = r_v[8] + w_d1;
    assign w_bx = r_v[4] ^ w_c1;
    assign w_b1 = r_h ? {w_bx[62:0], w_bx[63]} : {w_bx[23:0], w_bx[63:24]};

    // after a full G, rotate rows so the next column or diagonal sits in lane 0;
    // switch to diagonal order after G 3 and back after G 7
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            if (r_g == 3'd3) begin
                w_sh[r] = 2'(r + 1);
            end else if (r_g == 3'd7) begin
                w_sh[r] = 2'(1 - r);
            end else begin
                w_sh[r] = 2'd1;
            end
        end
        for (int i = 0; i < 16; i++) begin
            w_t[i] = r_v[i];
        end
        w_t[0]  = w_a1;
        w_t[4]  = w_b1;
        w_t[8]  = w_c1;
        w_t[12] = w_d1;
    end

    // ---------------------------------------------------------------
    // Restart values
    // ---------------------------------------------------------------
    assign w_new_dig = (w_cfg_hit && (i_cfg_idx == CFG_DIGEST_LENGTH)) ? i_cfg_wdata : r_dig;
    assign w_new_key = (w_cfg_hit && (i_cfg_idx == CFG_KEY_LENGTH)) ? i_cfg_wdata : r_key;
    assign w_param   = PARAM_BASE ^ (64'(eff_key_len(w_new_key)) << 8) ^
                       64'(eff_digest_len(w_new_dig));

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_in && (w_need_comp || w_fin)) begin
                    n_state = ST_INIT;
                end
            end
            ST_POST:   n_state = w_fin ? ST_INIT : ST_IDLE;
            ST_INIT:   n_state = ST_ROUND;
            ST_ROUND:  n_state = w_last_step ? ST_FINISH : ST_ROUND;
            ST_FINISH: n_state = r_last ? ST_OUT : ST_POST;
            ST_OUT: begin
                if (w_acc_out && o_digest_last) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
        if (w_cfg_hit) begin
            n_state = ST_IDLE;
        end
    end

    // ---------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------
    assign w_dlen = eff_digest_len(r_dig);
    assign w_nres = 4'((8'(w_dlen) + 8'd7) >> 3);
    assign w_rem  = w_dlen - {1'b0, r_k, 3'b000};
    assign w_nb   = (w_rem > 7'd8) ? 4'd8 : w_rem[3:0];

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_out_valid    = (r_state == ST_OUT);
        o_digest_word  = r_chain[r_k] & byte_mask(w_nb);
        o_digest_bytes = w_nb;
        o_digest_last  = ({1'b0, r_k} + 4'd1) == w_nres;
    end

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb begin
        n_dig       = r_dig;
        n_key       = r_key;
        n_chain     = r_chain;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_v         = r_v;
        n_round     = r_round;
        n_g         = r_g;
        n_h         = r_h;
        n_nwords    = r_nwords;
        n_last      = r_last;
        n_mvalid    = r_mvalid;
        n_pend_word = r_pend_word;
        n_pend_cnt  = r_pend_cnt;
        n_pend_fin  = r_pend_fin;
        n_k         = r_k;

        ram_we    = 1'b0;
        ram_waddr = r_fill[6:3];
        ram_wdata = w_word;

        // hold every accepted beat; it is replayed in POST after a full block
        if ((r_state == ST_IDLE) && w_acc_in) begin
            n_pend_word = w_word;
            n_pend_cnt  = w_cnt;
            n_pend_fin  = w_fin;
            if (w_need_comp) begin
                n_cnt    = r_cnt + 128'(BLOCK_BYTES);
                n_nwords = 5'(BUF_DEPTH);
                n_last   = 1'b0;
            end
        end

        // store the word, then either wait for more or close the message
        if (w_absorb) begin
            ram_we = (w_cnt != 4'd0);
            n_fill = w_fill_new;
            if (w_fin) begin
                n_cnt    = r_cnt + 128'(w_fill_new);
                n_nwords = 5'((9'(w_fill_new) + 9'd7) >> 3);
                n_last   = 1'b1;
            end
        end

        unique case (r_state)
            ST_INIT: begin
                for (int i = 0; i < 8; i++) begin
                    n_v[i]     = r_chain[i];
                    n_v[i + 8] = IV[i];
                end
                n_v[12]  = IV[4] ^ r_cnt[63:0];
                n_v[13]  = IV[5] ^ r_cnt[127:64];
                n_v[14]  = r_last ? (IV[6] ^ LAST_FLAG) : IV[6];
                n_round  = 4'd0;
                n_g      = 3'd0;
                n_h      = 1'b0;
                n_mvalid = {1'b0, ram_raddr} < r_nwords;
            end
            ST_ROUND: begin
                if (r_h) begin
                    for (int r = 0; r < 4; r++) begin
                        for (int c = 0; c < 4; c++) begin
                            n_v[r*4 + c] = w_t[{2'(r), 2'(c) + w_sh[r]}];
                        end
                    end
                end else begin
                    n_v = w_t;
                end
                n_round  = w_nx_round;
                n_g      = w_nx_g;
                n_h      = w_nx_h;
                // words past the message end read as zero padding
                n_mvalid = {1'b0, ram_raddr} < r_nwords;
            end
            ST_FINISH: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] ^ r_v[i] ^ r_v[i + 8];
                end
                if (r_last) begin
                    n_k = 3'd0;
                end else begin
                    n_fill = 8'd0;
                end
            end
            ST_OUT: begin
                if (w_acc_out && !o_digest_last) begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_IDLE, ST_POST: begin
            end
            default: begin
            end
        endcase

        // new message: fresh chain, count and fill
        if (w_restart) begin
            n_dig = w_new_dig;
            n_key = w_new_key;
            for (int i = 0; i < 8; i++) begin
                n_chain[i] = IV[i];
            end
            n_chain[0] = IV[0] ^ w_param;
            n_cnt      = '0;
            n_fill     = 8'd0;
            n_round    = 4'd0;
            n_k        = 3'd0;
            ram_we     = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dig   <= DIGEST_LEN_RESET;
            r_key   <= KEY_LEN_RESET;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= IV[i];
            end
            r_chain[0] <= IV[0] ^ PARAM_BASE ^ (64'(KEY_LEN_RESET) << 8) ^
                          64'(DIGEST_LEN_RESET);
            r_cnt    <= '0;
            r_fill   <= 8'd0;
            r_round  <= 4'd0;
            r_g      <= 3'd0;
            r_h      <= 1'b0;
            r_last   <= 1'b0;
            r_mvalid <= 1'b0;
            r_k      <= 3'd0;
            r_nwords <= 5'd0;
        end else begin
            r_state  <= n_state;
            r_dig    <= n_dig;
            r_key    <= n_key;
            r_chain  <= n_chain;
            r_cnt    <= n_cnt;
            r_fill   <= n_fill;
            r_round  <= n_round;
            r_g      <= n_g;
            r_h      <= n_h;
            r_last   <= n_last;
            r_mvalid <= n_mvalid;
            r_k      <= n_k;
            r_nwords <= n_nwords;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_v         <= n_v;
        r_pend_word <= n_pend_word;
        r_pend_cnt  <= n_pend_cnt;
        r_pend_fin  <= n_pend_fin;
    end

endmodule
